/* rtl/plfm_pkg.sv */
package plfm_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int THR_W      = 10;
	localparam int TIME_CFG_W = 24;
	localparam int TIME_W     = 32;
	localparam int DUTY_W     = 8;
	localparam int PCT_W      = 7;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;
	localparam int REG_IDX_W  = 3;

	// knob * 205 / 1023 as one multiply by a scaled reciprocal, exact for 10-bit knob values
	localparam int               DUTY_MULT_W = 26;
	localparam logic [25:0]      DUTY_MULT   = 26'd53792205;
	localparam int               DUTY_SHIFT  = 28;
	localparam logic [DUTY_W-1:0] DUTY_MIN   = 8'd50;
	localparam int               DIM_SHIFT   = 3;

	// mean * 100 / 1023, same scheme
	localparam int          PCT_MULT_W = 24;
	localparam logic [23:0] PCT_MULT   = 24'd13120100;
	localparam int          PCT_SHIFT  = 27;

	localparam logic [THR_W-1:0]      RST_LOW_LEVEL    = 10'd50;
	localparam logic [TIME_CFG_W-1:0] RST_FAULT_HOLD   = 24'd10000;
	localparam logic [TIME_CFG_W-1:0] RST_IDLE_TIMEOUT = 24'd20000;
	localparam logic [THR_W-1:0]      RST_LEVEL_MARGIN = 10'd2;
	localparam logic [THR_W-1:0]      RST_KNOB_MARGIN  = 10'd4;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LOW_LEVEL    = 3'd0,
		REG_FAULT_HOLD   = 3'd1,
		REG_IDLE_TIMEOUT = 3'd2,
		REG_LEVEL_MARGIN = 3'd3,
		REG_KNOB_MARGIN  = 3'd4
	} plfm_reg_t;

	typedef struct packed {
		logic [THR_W-1:0]      low_level_threshold;
		logic [TIME_CFG_W-1:0] fault_hold_ms;
		logic [TIME_CFG_W-1:0] idle_timeout_ms;
		logic [THR_W-1:0]      level_change_margin;
		logic [THR_W-1:0]      knob_change_margin;
	} plfm_cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mean_level;
		logic                pump_fault;
		logic [DUTY_W-1:0]   backlight_duty;
		logic                backlight_dimmed;
		logic [PCT_W-1:0]    level_percent;
	} plfm_result_t;

endpackage

/* rtl/plfm_regs.sv */
module plfm_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [plfm_pkg::ADDR_W-1:0]    paddr,
	input  logic [plfm_pkg::DATA_W-1:0]    pwdata,
	output logic [plfm_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	output plfm_pkg::plfm_cfg_t            cfg
);

	plfm_pkg::plfm_cfg_t cfg_q;
	plfm_pkg::plfm_reg_t reg_idx;
	logic                wr_en;

	assign reg_idx = plfm_pkg::plfm_reg_t'(paddr[plfm_pkg::ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_level_threshold <= plfm_pkg::RST_LOW_LEVEL;
			cfg_q.fault_hold_ms       <= plfm_pkg::RST_FAULT_HOLD;
			cfg_q.idle_timeout_ms     <= plfm_pkg::RST_IDLE_TIMEOUT;
			cfg_q.level_change_margin <= plfm_pkg::RST_LEVEL_MARGIN;
			cfg_q.knob_change_margin  <= plfm_pkg::RST_KNOB_MARGIN;
		end else if (wr_en) begin
			unique case (reg_idx)
				plfm_pkg::REG_LOW_LEVEL: begin
					cfg_q.low_level_threshold <= pwdata[plfm_pkg::THR_W-1:0];
				end
				plfm_pkg::REG_FAULT_HOLD: begin
					cfg_q.fault_hold_ms <= pwdata[plfm_pkg::TIME_CFG_W-1:0];
				end
				plfm_pkg::REG_IDLE_TIMEOUT: begin
					cfg_q.idle_timeout_ms <= pwdata[plfm_pkg::TIME_CFG_W-1:0];
				end
				plfm_pkg::REG_LEVEL_MARGIN: begin
					cfg_q.level_change_margin <= pwdata[plfm_pkg::THR_W-1:0];
				end
				plfm_pkg::REG_KNOB_MARGIN: begin
					cfg_q.knob_change_margin <= pwdata[plfm_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			plfm_pkg::REG_LOW_LEVEL: begin
				prdata = plfm_pkg::DATA_W'(cfg_q.low_level_threshold);
			end
			plfm_pkg::REG_FAULT_HOLD: begin
				prdata = plfm_pkg::DATA_W'(cfg_q.fault_hold_ms);
			end
			plfm_pkg::REG_IDLE_TIMEOUT: begin
				prdata = plfm_pkg::DATA_W'(cfg_q.idle_timeout_ms);
			end
			plfm_pkg::REG_LEVEL_MARGIN: begin
				prdata = plfm_pkg::DATA_W'(cfg_q.level_change_margin);
			end
			plfm_pkg::REG_KNOB_MARGIN: begin
				prdata = plfm_pkg::DATA_W'(cfg_q.knob_change_margin);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

/* rtl/plfm_window.sv */
module plfm_window #(
	parameter int WINDOW_LEN = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [plfm_pkg::SAMPLE_W-1:0] level,
	output logic [plfm_pkg::SAMPLE_W-1:0] mean,
	output logic                          first
);

	localparam int SLOT_W     = $clog2(WINDOW_LEN);
	localparam int TOT_W      = plfm_pkg::SAMPLE_W + SLOT_W;
	localparam int MULT_W     = TOT_W + 2;
	localparam int MEAN_SHIFT = TOT_W + SLOT_W;
	localparam int PROD_W     = TOT_W + MULT_W;
	// rounded-up reciprocal, exact floor division for every total below 2^TOT_W
	localparam logic [MULT_W-1:0] MEAN_MULT =
		MULT_W'(((64'd1 << MEAN_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

	logic [plfm_pkg::SAMPLE_W-1:0] win_mem_q [WINDOW_LEN];
	logic [plfm_pkg::SAMPLE_W-1:0] rd_q;
	logic [plfm_pkg::SAMPLE_W-1:0] first_level_q;
	logic [SLOT_W-1:0]             slot_q;
	logic [SLOT_W-1:0]             slot_next;
	logic [TOT_W-1:0]              total_q;
	logic                          primed_q;
	logic                          wrapped_q;

	logic [plfm_pkg::SAMPLE_W-1:0] old_level;
	logic [TOT_W-1:0]              base_total;
	logic [TOT_W-1:0]              total_new;
	logic [PROD_W-1:0]             mean_prod;

	assign slot_next = (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
	assign first     = !primed_q;

	// slots not yet overwritten since priming still hold the first sample
	always_comb begin
		if (!primed_q) begin
			old_level  = level;
			base_total = TOT_W'(level) * TOT_W'(WINDOW_LEN);
		end else begin
			old_level  = wrapped_q ? rd_q : first_level_q;
			base_total = total_q;
		end
		total_new = base_total - TOT_W'(old_level) + TOT_W'(level);
		mean_prod = PROD_W'(total_new) * PROD_W'(MEAN_MULT);
		mean      = mean_prod[MEAN_SHIFT +: plfm_pkg::SAMPLE_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			total_q   <= '0;
			primed_q  <= 1'b0;
			wrapped_q <= 1'b0;
		end else if (adv) begin
			slot_q   <= slot_next;
			total_q  <= total_new;
			primed_q <= 1'b1;
			if (slot_q == LAST_SLOT) begin
				wrapped_q <= 1'b1;
			end
		end
	end

	// next slot's entry is prefetched so it is ready when the next sample arrives
	always_ff @(posedge clk) begin
		if (adv) begin
			win_mem_q[slot_q] <= level;
			rd_q              <= win_mem_q[slot_next];
			if (!primed_q) begin
				first_level_q <= level;
			end
		end
	end

endmodule

/* rtl/plfm_monitor.sv */
module plfm_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  plfm_pkg::plfm_cfg_t           cfg,
	input  logic [plfm_pkg::SAMPLE_W-1:0] mean,
	input  logic [plfm_pkg::SAMPLE_W-1:0] knob,
	input  logic                          press,
	input  logic [plfm_pkg::TIME_W-1:0]   now,
	input  logic                          first,
	output plfm_pkg::plfm_result_t        result
);

	localparam int DUTY_PROD_W = plfm_pkg::SAMPLE_W + plfm_pkg::DUTY_MULT_W;
	localparam int PCT_PROD_W  = plfm_pkg::SAMPLE_W + plfm_pkg::PCT_MULT_W;

	logic                          fault_q;
	logic                          hold_q;
	logic [plfm_pkg::TIME_W-1:0]   hold_start_q;
	logic [plfm_pkg::TIME_W-1:0]   last_act_q;
	logic [plfm_pkg::SAMPLE_W-1:0] prev_mean_q;
	logic [plfm_pkg::SAMPLE_W-1:0] prev_knob_q;

	logic [plfm_pkg::SAMPLE_W-1:0] knob_ref;
	logic [plfm_pkg::TIME_W-1:0]   last_ref;
	logic [plfm_pkg::SAMPLE_W-1:0] mean_diff;
	logic [plfm_pkg::SAMPLE_W-1:0] knob_diff;
	logic                          active;
	logic [plfm_pkg::TIME_W-1:0]   last_new;
	logic [plfm_pkg::TIME_W-1:0]   idle_ms;
	logic [plfm_pkg::TIME_W-1:0]   held_ms;
	logic                          dimmed;
	logic                          fault_new;
	logic                          hold_new;
	logic [plfm_pkg::TIME_W-1:0]   hold_start_new;
	logic [DUTY_PROD_W-1:0]        duty_prod;
	logic [plfm_pkg::DUTY_W-1:0]   duty_base;
	logic [PCT_PROD_W-1:0]         pct_prod;

	always_comb begin
		knob_ref  = first ? knob : prev_knob_q;
		last_ref  = first ? now : last_act_q;
		mean_diff = (mean >= prev_mean_q) ? mean - prev_mean_q : prev_mean_q - mean;
		knob_diff = (knob >= knob_ref) ? knob - knob_ref : knob_ref - knob;
		active    = (mean_diff > cfg.level_change_margin) ||
			(knob_diff > cfg.knob_change_margin);
		last_new  = active ? now : last_ref;
		idle_ms   = now - last_new;
		dimmed    = idle_ms > plfm_pkg::TIME_W'(cfg.idle_timeout_ms);

		// first low item only arms the hold timer
		held_ms        = now - hold_start_q;
		fault_new      = fault_q;
		hold_new       = hold_q;
		hold_start_new = hold_start_q;
		if (mean <= cfg.low_level_threshold) begin
			if (!hold_q) begin
				hold_new       = 1'b1;
				hold_start_new = now;
			end else if (held_ms >= plfm_pkg::TIME_W'(cfg.fault_hold_ms)) begin
				fault_new = 1'b1;
			end
		end else begin
			hold_new  = 1'b0;
			fault_new = 1'b0;
		end
		if (press) begin
			fault_new      = 1'b0;
			hold_new       = 1'b0;
			hold_start_new = '0;
		end

		duty_prod = DUTY_PROD_W'(knob) * DUTY_PROD_W'(plfm_pkg::DUTY_MULT);
		duty_base = duty_prod[plfm_pkg::DUTY_SHIFT +: plfm_pkg::DUTY_W] + plfm_pkg::DUTY_MIN;
		pct_prod  = PCT_PROD_W'(mean) * PCT_PROD_W'(plfm_pkg::PCT_MULT);

		result.mean_level       = mean;
		result.pump_fault       = fault_new;
		result.backlight_duty   = dimmed ? (duty_base >> plfm_pkg::DIM_SHIFT) : duty_base;
		result.backlight_dimmed = dimmed;
		result.level_percent    = pct_prod[plfm_pkg::PCT_SHIFT +: plfm_pkg::PCT_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q      <= 1'b0;
			hold_q       <= 1'b0;
			hold_start_q <= '0;
			last_act_q   <= '0;
			prev_mean_q  <= '0;
			prev_knob_q  <= '0;
		end else if (adv) begin
			fault_q      <= fault_new;
			hold_q       <= hold_new;
			hold_start_q <= hold_start_new;
			last_act_q   <= press ? now : last_new;
			prev_mean_q  <= mean;
			prev_knob_q  <= knob;
		end
	end

endmodule

/* rtl/pump_level_fault_monitor_unit.sv */
// Pump level fault monitor: keeps a running mean over the last WINDOW_LEN level
// samples, raises pump_fault once the mean has stayed at or below the threshold
// for the hold time, and dims the knob-driven backlight duty after the idle
// timeout. One transaction is taken every clock cycle while item_stall is low;
// its result passes through three register stages (input, window mean, monitor
// result). The window lives in a small memory whose next entry is read ahead
// as each sample is written, so the running sum never stalls the pipe. Input and
// output stages are decoupled: a stalled result does not block new transactions
// until all three stages are full.
module pump_level_fault_monitor_unit #(
	parameter int WINDOW_LEN = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [plfm_pkg::ADDR_W-1:0]   paddr,
	input  logic [plfm_pkg::DATA_W-1:0]   pwdata,
	output logic [plfm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [plfm_pkg::SAMPLE_W-1:0] level_sample,
	input  logic [plfm_pkg::SAMPLE_W-1:0] knob_sample,
	input  logic                          reset_press,
	input  logic [plfm_pkg::TIME_W-1:0]   now_ms,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [plfm_pkg::SAMPLE_W-1:0] mean_level,
	output logic                          pump_fault,
	output logic [plfm_pkg::DUTY_W-1:0]   backlight_duty,
	output logic                          backlight_dimmed,
	output logic [plfm_pkg::PCT_W-1:0]    level_percent
);

	plfm_pkg::plfm_cfg_t    cfg;
	plfm_pkg::plfm_result_t result_comb;
	plfm_pkg::plfm_result_t result_s3;

	logic                          valid_s1;
	logic [plfm_pkg::SAMPLE_W-1:0] level_s1;
	logic [plfm_pkg::SAMPLE_W-1:0] knob_s1;
	logic                          press_s1;
	logic [plfm_pkg::TIME_W-1:0]   now_s1;

	logic                          valid_s2;
	logic [plfm_pkg::SAMPLE_W-1:0] mean_s2;
	logic [plfm_pkg::SAMPLE_W-1:0] knob_s2;
	logic                          press_s2;
	logic [plfm_pkg::TIME_W-1:0]   now_s2;
	logic                          first_s2;

	logic                          valid_s3;

	logic [plfm_pkg::SAMPLE_W-1:0] mean_comb;
	logic                          first_comb;
	logic                          en1;
	logic                          en2;
	logic                          en3;
	logic                          win_adv;
	logic                          mon_adv;

	// each stage moves when the one after it is empty or moving
	assign en3        = !valid_s3 || !result_stall;
	assign en2        = !valid_s2 || en3;
	assign en1        = !valid_s1 || en2;
	assign item_stall = !en1;
	assign win_adv    = valid_s1 && en2;
	assign mon_adv    = valid_s2 && en3;

	plfm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	plfm_window #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (win_adv),
		.level  (level_s1),
		.mean   (mean_comb),
		.first  (first_comb)
	);

	plfm_monitor u_monitor (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (mon_adv),
		.cfg    (cfg),
		.mean   (mean_s2),
		.knob   (knob_s2),
		.press  (press_s2),
		.now    (now_s2),
		.first  (first_s2),
		.result (result_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= item_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && item_valid) begin
			level_s1 <= level_sample;
			knob_s1  <= knob_sample;
			press_s1 <= reset_press;
			now_s1   <= now_ms;
		end
		if (win_adv) begin
			mean_s2  <= mean_comb;
			knob_s2  <= knob_s1;
			press_s2 <= press_s1;
			now_s2   <= now_s1;
			first_s2 <= first_comb;
		end
		if (mon_adv) begin
			result_s3 <= result_comb;
		end
	end

	assign result_valid     = valid_s3;
	assign mean_level       = result_s3.mean_level;
	assign pump_fault       = result_s3.pump_fault;
	assign backlight_duty   = result_s3.backlight_duty;
	assign backlight_dimmed = result_s3.backlight_dimmed;
	assign level_percent    = result_s3.level_percent;

	a_fault_means_low: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && pump_fault |-> mean_level <= cfg.low_level_threshold)
		else $error("fault reported with mean above threshold");

	a_dimmed_duty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && backlight_dimmed |-> backlight_duty <= 8'd31)
		else $error("dimmed duty not reduced");

	a_percent_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> level_percent <= 7'd100)
		else $error("level percent out of range");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && valid_s2 && valid_s3 && result_stall)
		else $error("input stalled while pipeline has room");

endmodule
